### hw/rtl/bmw_pkg.sv
`default_nettype none

package bmw_pkg;

    localparam int VERTEX_BITS = 10;
    localparam int IN_WEIGHT_BITS = 32;
    localparam int VCOUNT_BITS = 11;
    localparam int SUM_BITS = 48;
    localparam int S_TDATA_BITS = 56;
    localparam int M_TDATA_BITS = 48;

    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 11'd1024;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    typedef logic [VERTEX_BITS-1:0] vertex_t;

endpackage

`default_nettype wire

### hw/rtl/bmw_ram.sv
`default_nettype none

module bmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/boruvka_mst_weight.sv
`default_nettype none

// Minimum spanning forest weight by Boruvka rounds. Edges stream in on the slave side, one beat
// per cycle, and are written to the edge store; self-loops are dropped and edges beyond
// MAX_EDGES are dropped and flagged. The beat with tlast starts the computation and the input
// stalls until it ends. All state sits in three single-port-read RAMs (edges, labels, per
// component best edge), so the sequencer walks them one access a cycle: it resets the labels,
// drops out-of-range edges, then per round finds the minimum edge of each component, hooks
// each vertex, runs pointer-jump sweeps until a sweep changes nothing, and drops edges inside
// a component. The total then goes to the master-side output register, and loading of the
// next graph resumes as soon as that register is free.
module boruvka_mst_weight #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES = 4096,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // from_vertex, to_vertex, edge_weight
    input  wire logic [bmw_pkg::S_TDATA_BITS-1:0]      s_axis_tdata,
    input  wire logic                                  s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // total_weight
    output logic      [bmw_pkg::M_TDATA_BITS-1:0]      m_axis_tdata,
    // edge_overflow
    output logic                                       m_axis_tuser,
    input  wire logic                                  cfg_we,
    input  wire logic [bmw_pkg::VCOUNT_BITS-1:0]       cfg_wdata
);

    localparam int VB = bmw_pkg::VERTEX_BITS;
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int FW = $clog2(MAX_EDGES + 1);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = 2 * VB + WEIGHT_BITS;
    localparam int BW = 1 + WEIGHT_BITS + AW;
    localparam int SB = bmw_pkg::SUM_BITS;

    typedef enum logic [4:0] {
        ST_LOAD, ST_INIT,
        ST_C_RD, ST_C_LF, ST_C_LT, ST_C_W,
        ST_R_RD, ST_R_LF, ST_R_LT, ST_R_BF, ST_R_UF, ST_R_UT,
        ST_H_RD, ST_H_CHK, ST_H_LF, ST_H_LT, ST_H_LT2, ST_H_DEC,
        ST_J_RD, ST_J_M, ST_J_P,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] k_reg, k_next;
    logic [FW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] vc_reg, vc_next;
    logic range_reg, range_next;
    logic hooked_reg, hooked_next;
    logic changed_reg, changed_next;
    logic [SB-1:0] sum_reg, sum_next;
    logic ovf_reg, ovf_next;
    logic [bmw_pkg::VCOUNT_BITS-1:0] vcount_reg, vcount_next;
    bmw_pkg::vertex_t ef_reg, ef_next;
    bmw_pkg::vertex_t et_reg, et_next;
    logic [WEIGHT_BITS-1:0] ew_reg, ew_next;
    logic [VW-1:0] la_reg, la_next;
    logic [VW-1:0] lb_reg, lb_next;
    logic [WEIGHT_BITS-1:0] bw_reg, bw_next;
    logic [VW-1:0] other_reg, other_next;
    logic out_valid_reg, out_valid_next;
    logic [SB-1:0] out_sum_reg, out_sum_next;
    logic out_ovf_reg, out_ovf_next;

    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [SW-1:0] st_wdata, st_rdata;
    logic          lb_we;
    logic [VW-1:0] lb_waddr, lb_raddr, lb_wdata, lb_rdata;
    logic          bs_we;
    logic [VW-1:0] bs_waddr, bs_raddr;
    logic [BW-1:0] bs_wdata, bs_rdata;

    bmw_pkg::vertex_t in_from, in_to, rd_from, rd_to;
    logic [WEIGHT_BITS-1:0] in_w, rd_w, bs_w;
    logic bs_valid;
    logic [CW-1:0] vc_eff;
    logic [FW-1:0] fill_after;
    logic [SB:0] sum_add;

    assign in_from = s_axis_tdata[VB-1:0];
    assign in_to = s_axis_tdata[2*VB-1:VB];
    assign in_w = WEIGHT_BITS'(s_axis_tdata[2*VB+bmw_pkg::IN_WEIGHT_BITS-1:2*VB]);
    assign rd_from = st_rdata[VB-1:0];
    assign rd_to = st_rdata[2*VB-1:VB];
    assign rd_w = st_rdata[SW-1:2*VB];
    assign bs_valid = bs_rdata[BW-1];
    assign bs_w = bs_rdata[BW-2:AW];
    assign vc_eff = (32'(vcount_reg) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_reg);
    assign fill_after = (!range_reg && !hooked_reg) ? '0 : n_reg;
    assign sum_add = {1'b0, sum_reg} + (SB + 1)'(bw_reg);

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_sum_reg;
    assign m_axis_tuser = out_ovf_reg;

    bmw_ram #(.WIDTH(SW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    bmw_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_label_ram (
        .clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
        .raddr(lb_raddr), .rdata(lb_rdata)
    );

    bmw_ram #(.WIDTH(BW), .DEPTH(MAX_VERTICES)) u_best_ram (
        .clk(clk), .we(bs_we), .waddr(bs_waddr), .wdata(bs_wdata),
        .raddr(bs_raddr), .rdata(bs_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        k_next = k_reg;
        n_next = n_reg;
        i_next = i_reg;
        vc_next = vc_reg;
        range_next = range_reg;
        hooked_next = hooked_reg;
        changed_next = changed_reg;
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        vcount_next = cfg_we ? cfg_wdata : vcount_reg;
        ef_next = ef_reg;
        et_next = et_reg;
        ew_next = ew_reg;
        la_next = la_reg;
        lb_next = lb_reg;
        bw_next = bw_reg;
        other_next = other_reg;
        out_valid_next = (out_valid_reg && m_axis_tready) ? 1'b0 : out_valid_reg;
        out_sum_next = out_sum_reg;
        out_ovf_next = out_ovf_reg;

        st_we = 1'b0;
        st_waddr = n_reg[AW-1:0];
        st_wdata = {ew_reg, et_reg, ef_reg};
        st_raddr = k_reg[AW-1:0];
        lb_we = 1'b0;
        lb_waddr = i_reg[VW-1:0];
        lb_wdata = i_reg[VW-1:0];
        lb_raddr = VW'(ef_reg);
        bs_we = 1'b0;
        bs_waddr = la_reg;
        bs_wdata = {1'b1, ew_reg, k_reg[AW-1:0]};
        bs_raddr = la_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_from != in_to)
                    begin
                        if (fill_reg < FW'(MAX_EDGES))
                        begin
                            st_we = 1'b1;
                            st_waddr = fill_reg[AW-1:0];
                            st_wdata = {in_w, in_to, in_from};
                            fill_next = fill_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        vc_next = vc_eff;
                        i_next = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                if (i_reg == vc_reg)
                begin
                    k_next = '0;
                    n_next = '0;
                    range_next = 1'b1;
                    state_next = ST_C_RD;
                end
                else
                begin
                    lb_we = 1'b1;
                    bs_we = 1'b1;
                    bs_waddr = i_reg[VW-1:0];
                    bs_wdata = '0;
                    i_next = i_reg + 1'b1;
                end
            end
            ST_C_RD:
            begin
                if (k_reg == fill_reg)
                begin
                    fill_next = fill_after;
                    k_next = '0;
                    hooked_next = 1'b0;
                    state_next = (fill_after == '0) ? ST_DONE : ST_R_RD;
                end
                else
                begin
                    state_next = ST_C_LF;
                end
            end
            ST_C_LF:
            begin
                ef_next = rd_from;
                et_next = rd_to;
                ew_next = rd_w;
                if (range_reg)
                begin
                    if (32'(rd_from) < 32'(vc_reg) && 32'(rd_to) < 32'(vc_reg))
                    begin
                        st_we = 1'b1;
                        st_wdata = st_rdata;
                        n_next = n_reg + 1'b1;
                    end
                    k_next = k_reg + 1'b1;
                    state_next = ST_C_RD;
                end
                else
                begin
                    lb_raddr = VW'(rd_from);
                    state_next = ST_C_LT;
                end
            end
            ST_C_LT:
            begin
                la_next = lb_rdata;
                lb_raddr = VW'(et_reg);
                state_next = ST_C_W;
            end
            ST_C_W:
            begin
                if (la_reg != lb_rdata)
                begin
                    st_we = 1'b1;
                    n_next = n_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
                state_next = ST_C_RD;
            end
            ST_R_RD:
            begin
                if (k_reg == fill_reg)
                begin
                    i_next = '0;
                    state_next = ST_H_RD;
                end
                else
                begin
                    state_next = ST_R_LF;
                end
            end
            ST_R_LF:
            begin
                ef_next = rd_from;
                et_next = rd_to;
                ew_next = rd_w;
                lb_raddr = VW'(rd_from);
                state_next = ST_R_LT;
            end
            ST_R_LT:
            begin
                la_next = lb_rdata;
                lb_raddr = VW'(et_reg);
                state_next = ST_R_BF;
            end
            ST_R_BF:
            begin
                lb_next = lb_rdata;
                bs_raddr = la_reg;
                state_next = ST_R_UF;
            end
            ST_R_UF:
            begin
                if (!bs_valid || ew_reg < bs_w)
                begin
                    bs_we = 1'b1;
                end
                bs_raddr = lb_reg;
                state_next = ST_R_UT;
            end
            ST_R_UT:
            begin
                if (!bs_valid || ew_reg < bs_w)
                begin
                    bs_we = 1'b1;
                    bs_waddr = lb_reg;
                end
                k_next = k_reg + 1'b1;
                state_next = ST_R_RD;
            end
            ST_H_RD:
            begin
                if (i_reg == vc_reg)
                begin
                    i_next = '0;
                    changed_next = 1'b0;
                    state_next = ST_J_RD;
                end
                else
                begin
                    bs_raddr = i_reg[VW-1:0];
                    state_next = ST_H_CHK;
                end
            end
            ST_H_CHK:
            begin
                if (!bs_valid)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_H_RD;
                end
                else
                begin
                    bw_next = bs_w;
                    bs_we = 1'b1;
                    bs_waddr = i_reg[VW-1:0];
                    bs_wdata = '0;
                    st_raddr = bs_rdata[AW-1:0];
                    state_next = ST_H_LF;
                end
            end
            ST_H_LF:
            begin
                ef_next = rd_from;
                et_next = rd_to;
                lb_raddr = VW'(rd_from);
                state_next = ST_H_LT;
            end
            ST_H_LT:
            begin
                if (32'(lb_rdata) != 32'(i_reg))
                begin
                    other_next = lb_rdata;
                    state_next = ST_H_DEC;
                end
                else
                begin
                    lb_raddr = VW'(et_reg);
                    state_next = ST_H_LT2;
                end
            end
            ST_H_LT2:
            begin
                other_next = lb_rdata;
                state_next = ST_H_DEC;
            end
            ST_H_DEC:
            begin
                if (32'(other_reg) < 32'(i_reg))
                begin
                    sum_next = sum_add[SB] ? bmw_pkg::SUM_MAX : sum_add[SB-1:0];
                    lb_we = 1'b1;
                    lb_wdata = other_reg;
                    hooked_next = 1'b1;
                end
                i_next = i_reg + 1'b1;
                state_next = ST_H_RD;
            end
            ST_J_RD:
            begin
                if (i_reg == vc_reg)
                begin
                    i_next = '0;
                    if (changed_reg)
                    begin
                        changed_next = 1'b0;
                    end
                    else
                    begin
                        k_next = '0;
                        n_next = '0;
                        range_next = 1'b0;
                        state_next = ST_C_RD;
                    end
                end
                else
                begin
                    lb_raddr = i_reg[VW-1:0];
                    state_next = ST_J_M;
                end
            end
            ST_J_M:
            begin
                la_next = lb_rdata;
                lb_raddr = lb_rdata;
                state_next = ST_J_P;
            end
            ST_J_P:
            begin
                if (lb_rdata != la_reg)
                begin
                    lb_we = 1'b1;
                    lb_wdata = lb_rdata;
                    changed_next = 1'b1;
                end
                i_next = i_reg + 1'b1;
                state_next = ST_J_RD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next = sum_reg;
                    out_ovf_next = ovf_reg;
                    sum_next = '0;
                    ovf_next = 1'b0;
                    fill_next = '0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            fill_reg <= '0;
            k_reg <= '0;
            n_reg <= '0;
            i_reg <= '0;
            vc_reg <= '0;
            range_reg <= 1'b0;
            hooked_reg <= 1'b0;
            changed_reg <= 1'b0;
            sum_reg <= '0;
            ovf_reg <= 1'b0;
            vcount_reg <= bmw_pkg::VCOUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            k_reg <= k_next;
            n_reg <= n_next;
            i_reg <= i_next;
            vc_reg <= vc_next;
            range_reg <= range_next;
            hooked_reg <= hooked_next;
            changed_reg <= changed_next;
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
            vcount_reg <= vcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ef_reg <= ef_next;
        et_reg <= et_next;
        ew_reg <= ew_next;
        la_reg <= la_next;
        lb_reg <= lb_next;
        bw_reg <= bw_next;
        other_reg <= other_next;
        out_sum_reg <= out_sum_next;
        out_ovf_reg <= out_ovf_next;
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(MAX_EDGES))
        else $error("edge fill beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD && state_reg != ST_DONE) |=> sum_reg >= $past(sum_reg))
        else $error("weight sum decreased during rounds");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside done state");
`endif

endmodule

`default_nettype wire
